// ===== rtl/core/bml_pkg.sv =====
// Package: constants, register codes and exp(-x) sample table for the beam likelihood block.
`timescale 1ns / 1ps
package bml_pkg;

    localparam int RANGE_BITS        = 16;
    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int SUM_BITS_DEF      = 24;
    localparam int REG_BITS          = 16;
    localparam int REG_IDX_BITS      = 3;
    localparam int WEIGHT_BITS       = 24;
    localparam int EXP_X_BITS        = 12;
    localparam int EXP_IDX_BITS      = $clog2(EXP_TABLE_ENTRIES);
    localparam int MUL_A_BITS        = 32;
    localparam int MUL_B_BITS        = 16;
    localparam int MUL_P_BITS        = MUL_A_BITS + MUL_B_BITS;
    localparam int HIT_SHIFT         = 20;
    localparam int SHORT_X_SHIFT     = 14;
    localparam int COEF_SHIFT        = 12;
    localparam int Q16_SHIFT         = 16;
    localparam int COEF_BITS         = 20;
    localparam int PZ_BITS           = 21;

    localparam logic [REG_IDX_BITS-1:0] REG_HIT_WEIGHT    = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_SHORT_WEIGHT  = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_MAX_WEIGHT    = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_RANDOM_DENS   = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_HIT_PRECISION = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_SHORT_RATE    = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_RANGE_LIMIT   = 3'd6;

    localparam logic [REG_BITS-1:0] RST_HIT_WEIGHT    = 16'd52429;
    localparam logic [REG_BITS-1:0] RST_SHORT_WEIGHT  = 16'd6554;
    localparam logic [REG_BITS-1:0] RST_MAX_WEIGHT    = 16'd3277;
    localparam logic [REG_BITS-1:0] RST_RANDOM_DENS   = 16'd109;
    localparam logic [REG_BITS-1:0] RST_HIT_PRECISION = 16'd5689;
    localparam logic [REG_BITS-1:0] RST_SHORT_RATE    = 16'd41;
    localparam logic [REG_BITS-1:0] RST_RANGE_LIMIT   = 16'd30720;

    typedef logic [15:0] t_exp_tab [EXP_TABLE_ENTRIES];

    // exp(-step) by Taylor sum in Q30, then a running product rounded to Q0.16
    function automatic t_exp_tab build_exp_table();
        logic [63:0] d;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] v;
        t_exp_tab    tab;
        d    = (64'd16 << 30) / EXP_TABLE_ENTRIES;
        term = 64'd1 << 30;
        pos  = 64'd1 << 30;
        neg  = 64'd0;
        e    = 64'd1 << 30;
        for (int k = 1; k <= 24; k++) begin
            term = ((term * d) >> 30) / 64'(k);
            if ((k % 2) == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        r = (pos > neg) ? (pos - neg) : 64'd0;
        for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
            v      = (e + (64'd1 << 13)) >> 14;
            tab[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
            e      = (e * r) >> 30;
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TABLE = build_exp_table();

endpackage

// ===== rtl/core/bml_beam_if.sv =====
// Interface: beam input channel (valid/ready plus beam fields).
`timescale 1ns / 1ps
interface bml_beam_if;
    logic                            valid;
    logic                            ready;
    logic [bml_pkg::RANGE_BITS-1:0] measured_range;
    logic [bml_pkg::RANGE_BITS-1:0] expected_range;
    logic                            last_beam;

    modport source (output valid, output measured_range, output expected_range,
                    output last_beam, input ready);
    modport sink   (input valid, input measured_range, input expected_range,
                    input last_beam, output ready);
endinterface

// ===== rtl/core/bml_weight_if.sv =====
// Interface: particle weight output channel (valid/ready plus weight fields).
`timescale 1ns / 1ps
interface bml_weight_if;
    logic                             valid;
    logic                             ready;
    logic [bml_pkg::WEIGHT_BITS-1:0] particle_weight;
    logic                             saturated;

    modport source (output valid, output particle_weight, output saturated, input ready);
    modport sink   (input valid, input particle_weight, input saturated, output ready);
endinterface

// ===== rtl/core/beam_model_likelihood_accumulator_top.sv =====
// Top level: beam-model likelihood accumulator on one shared multiplier.
//
//  port       dir  handshake      item
//  i_beam     in   valid/ready    measured_range, expected_range, last_beam
//  o_weight   out  valid/ready    particle_weight, saturated (last beam only)
//  i_cfg_*    in   write enable   register index, 16-bit data
//
// A beam holds the sequencer through Z2, HX, EXP, HW, MIX, C1, C2 and ACC (with SC, SX, a second
// EXP and SA added when measured < expected, for the short term); the next beam waits for idle.
// Every multiply goes through the one 32x16 multiplier under the sequencer.
// i_beam.ready is high only while the sequencer is idle.
// A last beam waits in its final step while the output register is full and not being read.
// Synchronous active-low reset loads register defaults and sets the sum to 1.0.
`timescale 1ns / 1ps
module beam_model_likelihood_accumulator_top #(
    parameter int SUM_BITS = bml_pkg::SUM_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bml_beam_if.sink                          i_beam,
    bml_weight_if.source                      o_weight,
    input  logic                              i_cfg_we,
    input  logic [bml_pkg::REG_IDX_BITS-1:0] i_cfg_index,
    input  logic [bml_pkg::REG_BITS-1:0]     i_cfg_data
);

    localparam int RB  = bml_pkg::RANGE_BITS;
    localparam int XB  = bml_pkg::EXP_X_BITS;
    localparam int IB  = bml_pkg::EXP_IDX_BITS;
    localparam int PB  = bml_pkg::MUL_P_BITS;
    localparam int AB  = bml_pkg::MUL_A_BITS;
    localparam int BB  = bml_pkg::MUL_B_BITS;
    localparam int OWB = bml_pkg::WEIGHT_BITS;
    localparam logic [SUM_BITS-1:0] SUM_ONE = SUM_BITS'(65536);
    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_Z2   = 12'b0000_0000_0010,
        S_HX   = 12'b0000_0000_0100,
        S_EXP  = 12'b0000_0000_1000,
        S_HW   = 12'b0000_0001_0000,
        S_SC   = 12'b0000_0010_0000,
        S_SX   = 12'b0000_0100_0000,
        S_SA   = 12'b0000_1000_0000,
        S_MIX  = 12'b0001_0000_0000,
        S_C1   = 12'b0010_0000_0000,
        S_C2   = 12'b0100_0000_0000,
        S_ACC  = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_hit_weight, r_short_weight, r_max_weight, r_random_dens;
    logic [15:0] r_hit_precision, r_short_rate, r_range_limit;

    logic [RB-1:0]                 r_m, r_az;
    logic                          r_short, r_last, r_phase;
    logic [AB-1:0]                 r_a;
    logic [XB-1:0]                 r_x;
    logic                          r_xbig;
    logic [15:0]                   r_exp;
    logic [bml_pkg::COEF_BITS-1:0] r_coef;
    logic [bml_pkg::PZ_BITS-1:0]   r_pz;
    logic [15:0]                   r_pz16;
    logic [SUM_BITS-1:0]           r_sum;
    logic                          r_clip;
    logic                          r_ov;
    logic [OWB-1:0]                r_ow;
    logic                          r_osat;

    logic [AB-1:0] w_ma;
    logic [BB-1:0] w_mb;
    logic [PB-1:0] w_prod;

    // table interpolation
    logic [XB+IB-1:0] w_p;
    logic [IB-1:0]    w_idx;
    logic [IB:0]      w_idx1;
    logic [XB-1:0]    w_frac;
    logic [15:0]      w_e0, w_e1, w_delta, w_step, w_y;
    logic             w_dn;

    logic [bml_pkg::PZ_BITS-1:0] w_pz_mix;
    logic [SUM_BITS:0]           w_sum_add;
    logic                        w_sum_ovf;
    logic [SUM_BITS-1:0]         w_sum_new;
    logic [SUM_BITS+OWB-1:0]     w_sum_ext;
    logic                        w_slot;
    logic                        w_acc_go;

    assign i_beam.ready = (r_state == S_IDLE);
    assign o_weight.valid = r_ov;
    assign o_weight.particle_weight = r_ow;
    assign o_weight.saturated = r_osat;

    assign w_slot   = !r_ov || o_weight.ready;
    assign w_acc_go = !r_last || w_slot;

    always_comb begin
        w_p    = (XB+IB)'(r_x) * (XB+IB)'(bml_pkg::EXP_TABLE_ENTRIES);
        w_idx  = w_p[XB+IB-1:XB];
        w_frac = w_p[XB-1:0];
        w_idx1 = {1'b0, w_idx} + (IB+1)'(1);
        w_e0   = bml_pkg::EXP_TABLE[w_idx];
        w_e1   = (w_idx1 < (IB+1)'(bml_pkg::EXP_TABLE_ENTRIES))
               ? bml_pkg::EXP_TABLE[w_idx1[IB-1:0]] : 16'd0;
        w_dn    = (w_e0 >= w_e1);
        w_delta = w_dn ? (w_e0 - w_e1) : (w_e1 - w_e0);
    end

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_Z2: begin
                w_ma = AB'(r_az);
                w_mb = BB'(r_az);
            end
            S_HX: begin
                w_ma = r_a;
                w_mb = r_hit_precision;
            end
            S_EXP: begin
                w_ma = AB'(w_delta);
                w_mb = BB'(w_frac);
            end
            S_HW: begin
                w_ma = AB'(r_hit_weight);
                w_mb = r_exp;
            end
            S_SC: begin
                w_ma = AB'(r_short_weight);
                w_mb = r_short_rate;
            end
            S_SX: begin
                w_ma = AB'(r_m);
                w_mb = r_short_rate;
            end
            S_SA: begin
                w_ma = AB'(r_coef);
                w_mb = r_exp;
            end
            S_C1: begin
                w_ma = AB'(r_pz16);
                w_mb = r_pz16;
            end
            S_C2: begin
                w_ma = r_a;
                w_mb = r_pz16;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_step = w_prod[XB+15:XB];
    assign w_y    = w_dn ? (w_e0 - w_step) : (w_e0 + w_step);

    assign w_pz_mix = r_pz + bml_pkg::PZ_BITS'((r_m >= r_range_limit) ? r_max_weight
                                                                      : r_random_dens);
    assign w_sum_add = {1'b0, r_sum} + (SUM_BITS+1)'(r_a[15:0]);
    assign w_sum_ovf = w_sum_add[SUM_BITS];
    assign w_sum_new = w_sum_ovf ? SUM_MAX : w_sum_add[SUM_BITS-1:0];
    assign w_sum_ext = (SUM_BITS+OWB)'(w_sum_new);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_beam.valid) n_state = S_Z2;
            S_Z2:   n_state = S_HX;
            S_HX:   n_state = S_EXP;
            S_EXP:  n_state = r_phase ? S_SA : S_HW;
            S_HW:   n_state = r_short ? S_SC : S_MIX;
            S_SC:   n_state = S_SX;
            S_SX:   n_state = S_EXP;
            S_SA:   n_state = S_MIX;
            S_MIX:  n_state = S_C1;
            S_C1:   n_state = S_C2;
            S_C2:   n_state = S_ACC;
            S_ACC:  if (w_acc_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_hit_weight    <= bml_pkg::RST_HIT_WEIGHT;
            r_short_weight  <= bml_pkg::RST_SHORT_WEIGHT;
            r_max_weight    <= bml_pkg::RST_MAX_WEIGHT;
            r_random_dens   <= bml_pkg::RST_RANDOM_DENS;
            r_hit_precision <= bml_pkg::RST_HIT_PRECISION;
            r_short_rate    <= bml_pkg::RST_SHORT_RATE;
            r_range_limit   <= bml_pkg::RST_RANGE_LIMIT;
            r_sum           <= SUM_ONE;
            r_clip          <= 1'b0;
            r_ov            <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bml_pkg::REG_HIT_WEIGHT:    r_hit_weight    <= i_cfg_data;
                    bml_pkg::REG_SHORT_WEIGHT:  r_short_weight  <= i_cfg_data;
                    bml_pkg::REG_MAX_WEIGHT:    r_max_weight    <= i_cfg_data;
                    bml_pkg::REG_RANDOM_DENS:   r_random_dens   <= i_cfg_data;
                    bml_pkg::REG_HIT_PRECISION: r_hit_precision <= i_cfg_data;
                    bml_pkg::REG_SHORT_RATE:    r_short_rate    <= i_cfg_data;
                    bml_pkg::REG_RANGE_LIMIT:   r_range_limit   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_ACC && w_acc_go) begin
                if (r_last) begin
                    r_ov   <= 1'b1;
                    r_ow   <= w_sum_ext[OWB-1:0];
                    r_osat <= r_clip || w_sum_ovf;
                    r_sum  <= SUM_ONE;
                    r_clip <= 1'b0;
                end else begin
                    r_sum  <= w_sum_new;
                    r_clip <= r_clip || w_sum_ovf;
                    if (o_weight.ready) begin
                        r_ov <= 1'b0;
                    end
                end
            end else if (o_weight.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_m     <= i_beam.measured_range;
                r_short <= (i_beam.measured_range < i_beam.expected_range);
                r_az    <= (i_beam.measured_range < i_beam.expected_range)
                         ? (i_beam.expected_range - i_beam.measured_range)
                         : (i_beam.measured_range - i_beam.expected_range);
                r_last  <= i_beam.last_beam;
                r_phase <= 1'b0;
                r_pz    <= '0;
            end
            S_Z2: r_a <= w_prod[AB-1:0];
            S_HX: begin
                r_x    <= w_prod[bml_pkg::HIT_SHIFT+XB-1:bml_pkg::HIT_SHIFT];
                r_xbig <= |w_prod[PB-1:bml_pkg::HIT_SHIFT+XB];
            end
            S_EXP: r_exp <= r_xbig ? 16'd0 : w_y;
            S_HW: r_pz <= bml_pkg::PZ_BITS'(w_prod[PB-1:bml_pkg::Q16_SHIFT]);
            S_SC: r_coef <= w_prod[bml_pkg::COEF_SHIFT+bml_pkg::COEF_BITS-1:
                                   bml_pkg::COEF_SHIFT];
            S_SX: begin
                r_x     <= w_prod[bml_pkg::SHORT_X_SHIFT+XB-1:bml_pkg::SHORT_X_SHIFT];
                r_xbig  <= |w_prod[PB-1:bml_pkg::SHORT_X_SHIFT+XB];
                r_phase <= 1'b1;
            end
            S_SA: r_pz <= r_pz + bml_pkg::PZ_BITS'(w_prod[PB-1:bml_pkg::Q16_SHIFT]);
            S_MIX: r_pz16 <= (w_pz_mix > bml_pkg::PZ_BITS'(16'hFFFF)) ? 16'hFFFF
                                                                       : w_pz_mix[15:0];
            S_C1: r_a <= w_prod[PB-1:bml_pkg::Q16_SHIFT];
            S_C2: r_a <= w_prod[PB-1:bml_pkg::Q16_SHIFT];
            S_ACC: ;
            default: ;
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_beam.valid && i_beam.ready) |=> (r_state == S_Z2))
        else $error("accepted item did not start the sequence");

    a_out_from_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> ($past(r_state) == S_ACC && $past(r_last)))
        else $error("result loaded outside the accumulate step of a last beam");

    a_sum_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && r_last && w_slot) |=> (r_sum == SUM_ONE && !r_clip))
        else $error("accumulator not restarted after last beam");

    a_sum_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_sum >= SUM_ONE))
        else $error("accumulator below 1.0");

endmodule
